// ===== src/ert_pkg.sv =====
package ert_pkg;

    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

    typedef struct packed {
        logic index_armed;
        logic latch_pos_armed;
        logic latch_neg_armed;
        logic set_pending;
    } t_flags;

    // what the front hands to the back for one operational request
    typedef struct packed {
        logic signed [31:0] hw_count;
        logic signed [31:0] ext_latch;
        logic signed [31:0] rel_count;
        t_flags             flags;
    } t_entry;

    typedef struct packed {
        logic signed [31:0] hw_count;
        logic signed [31:0] ext_latch;
        logic signed [31:0] rel_count;
        logic signed [63:0] position;
        t_flags             flags;
    } t_result;

endpackage

// ===== src/ert_fifo.sv =====
module ert_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

endmodule

// ===== src/ert_front.sv =====
module ert_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_operational,
    input  logic signed [31:0]  i_hw_count,
    input  logic signed [31:0]  i_ext_latch,
    input  logic                i_latch_valid,
    input  logic                i_set_done,
    input  logic                i_index_level,
    input  logic                i_reset_req,
    input  logic                i_arm_index,
    input  logic                i_arm_latch_pos,
    input  logic                i_arm_latch_neg,
    input  logic                i_request_set,
    output logic                o_wr,
    output ert_pkg::t_entry     o_entry
);

    logic signed [31:0] r_base, r_rel, r_count_hold, r_latch_hold;
    logic               r_prev_index, r_need_init, r_was_oper;
    ert_pkg::t_flags    r_flags;

    logic signed [31:0] n_base, n_rel, n_count_hold, n_latch_hold;
    ert_pkg::t_flags    n_flags;
    logic               w_edge, w_init, w_step;

    assign w_step = i_take && i_operational;

    always_comb begin
        n_flags.set_pending     = (r_flags.set_pending | i_request_set) & ~i_set_done;
        n_flags.index_armed     = r_flags.index_armed | i_arm_index;
        n_flags.latch_pos_armed = r_flags.latch_pos_armed | i_arm_latch_pos;
        n_flags.latch_neg_armed = r_flags.latch_neg_armed | i_arm_latch_neg;

        // base is the last raw count unless the link just came up
        n_base = r_was_oper ? r_base : i_hw_count;
        if (i_set_done) begin
            n_base = i_hw_count;
        end
        n_count_hold = n_flags.set_pending ? r_count_hold : i_hw_count;
        n_latch_hold = r_latch_hold;

        w_init = r_need_init | i_reset_req;
        // an index edge coinciding with init or reset is dropped
        w_edge = i_index_level & ~r_prev_index & ~w_init;
        n_rel  = r_rel;
        if (w_init) begin
            n_base = i_hw_count;
            n_rel  = '0;
        end
        if (i_latch_valid) begin
            n_latch_hold            = i_ext_latch;
            n_base                  = i_ext_latch;
            n_rel                   = '0;
            n_flags.latch_pos_armed = 1'b0;
            n_flags.latch_neg_armed = 1'b0;
        end
        if (w_edge && n_flags.index_armed) begin
            n_base              = i_hw_count;
            n_rel               = '0;
            n_flags.index_armed = 1'b0;
        end
        n_rel = n_rel + (i_hw_count - n_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_rel        <= '0;
            r_count_hold <= '0;
            r_latch_hold <= '0;
            r_prev_index <= 1'b0;
            r_need_init  <= 1'b1;
            r_was_oper   <= 1'b0;
            r_flags      <= '0;
        end else if (w_step) begin
            r_base       <= i_hw_count;
            r_rel        <= n_rel;
            r_count_hold <= n_count_hold;
            r_latch_hold <= n_latch_hold;
            r_prev_index <= i_index_level;
            r_need_init  <= 1'b0;
            r_was_oper   <= 1'b1;
            r_flags      <= n_flags;
        end else if (i_take) begin
            r_was_oper <= 1'b0;
        end
    end

    assign o_wr               = w_step;
    assign o_entry.hw_count   = n_count_hold;
    assign o_entry.ext_latch  = n_latch_hold;
    assign o_entry.rel_count  = n_rel;
    assign o_entry.flags      = n_flags;

    a_init_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> !r_need_init && r_was_oper)
        else $error("operational request left init pending");

    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_reset_req && !i_latch_valid) |-> (o_entry.rel_count == '0))
        else $error("reset request did not zero the relative count");

endmodule

// ===== src/ert_back.sv =====
module ert_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_scale,
    input  logic               i_mid_empty,
    input  ert_pkg::t_entry    i_mid_entry,
    output logic               o_mid_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output ert_pkg::t_result   o_result
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int RES_W = $bits(ert_pkg::t_result);

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_mul_vld;
    ert_pkg::t_result   r_mul;
    logic signed [63:0] w_prod;
    logic               w_issue, w_out_pop, w_out_full;
    logic [RES_W-1:0]   w_out_data;

    // count covers the multiplier stage plus the output queue, so a slot is held
    assign w_issue   = !i_mid_empty && (r_cnt < CNT_W'(OUT_DEPTH));
    assign o_mid_pop = w_issue;
    assign w_out_pop = i_pop && !o_empty;
    assign w_prod    = 64'(i_mid_entry.rel_count) * 64'(i_scale);

    always_comb begin
        n_cnt = r_cnt;
        case ({w_issue, w_out_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul.hw_count  <= i_mid_entry.hw_count;
        r_mul.ext_latch <= i_mid_entry.ext_latch;
        r_mul.rel_count <= i_mid_entry.rel_count;
        r_mul.flags     <= i_mid_entry.flags;
        r_mul.position  <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_mul_vld <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_mul_vld <= w_issue;
        end
    end

    ert_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_mul_vld),
        .i_data  (r_mul),
        .o_full  (w_out_full),
        .i_pop   (w_out_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty)
    );

    assign o_result = ert_pkg::t_result'(w_out_data);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(OUT_DEPTH))
        else $error("output credit count overflow");

    a_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_vld |-> !w_out_full)
        else $error("multiplier result has no output slot");

endmodule

// ===== src/encoder_relative_count_tracker_top.sv =====
// Encoder relative count tracker, one channel. Every request taken with operational set
// returns one result; other requests update only the link-up tracking and return nothing.
// One request is accepted per clock while the middle queue has room; a result passes the
// middle queue, then the registered 32x32 multiply that forms the signed Q48.16 position,
// and then the output queue before it is visible.
// Front (count/flag update) and back (multiply, output queue) are split by a small queue.
// The scale register resets to 1.0 and should be written only while the block is idle.
module encoder_relative_count_tracker_top #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic               i_operational,
    input  logic signed [31:0] i_hw_count,
    input  logic signed [31:0] i_ext_latch,
    input  logic               i_latch_valid,
    input  logic               i_set_done,
    input  logic               i_index_level,
    input  logic               i_reset_req,
    input  logic               i_arm_index,
    input  logic               i_arm_latch_pos,
    input  logic               i_arm_latch_neg,
    input  logic               i_request_set,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_hw_count_out,
    output logic signed [31:0] o_ext_latch_out,
    output logic signed [31:0] o_rel_count,
    output logic signed [63:0] o_position,
    output logic               o_index_armed_out,
    output logic               o_latch_pos_armed_out,
    output logic               o_latch_neg_armed_out,
    output logic               o_set_pending_out
);

    localparam int ENT_W = $bits(ert_pkg::t_entry);

    logic signed [31:0] r_scale;
    logic               w_take, w_wr, w_mid_empty, w_mid_pop;
    ert_pkg::t_entry    w_entry;
    logic [ENT_W-1:0]   w_mid_data;
    ert_pkg::t_result   w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ert_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    assign w_take = push && !full;

    ert_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_operational   (i_operational),
        .i_hw_count      (i_hw_count),
        .i_ext_latch     (i_ext_latch),
        .i_latch_valid   (i_latch_valid),
        .i_set_done      (i_set_done),
        .i_index_level   (i_index_level),
        .i_reset_req     (i_reset_req),
        .i_arm_index     (i_arm_index),
        .i_arm_latch_pos (i_arm_latch_pos),
        .i_arm_latch_neg (i_arm_latch_neg),
        .i_request_set   (i_request_set),
        .o_wr            (w_wr),
        .o_entry         (w_entry)
    );

    ert_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_wr),
        .i_data  (w_entry),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty)
    );

    ert_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_scale),
        .i_mid_empty (w_mid_empty),
        .i_mid_entry (ert_pkg::t_entry'(w_mid_data)),
        .o_mid_pop   (w_mid_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_hw_count_out        = w_result.hw_count;
    assign o_ext_latch_out       = w_result.ext_latch;
    assign o_rel_count           = w_result.rel_count;
    assign o_position            = w_result.position;
    assign o_index_armed_out     = w_result.flags.index_armed;
    assign o_latch_pos_armed_out = w_result.flags.latch_pos_armed;
    assign o_latch_neg_armed_out = w_result.flags.latch_neg_armed;
    assign o_set_pending_out     = w_result.flags.set_pending;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 244;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 8;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic               operational;
        logic signed [31:0] hw_count;
        logic signed [31:0] ext_latch;
        logic               latch_valid;
        logic               set_done;
        logic               index_level;
        logic               reset_req;
        logic               arm_index;
        logic               arm_latch_pos;
        logic               arm_latch_neg;
        logic               request_set;
    } t_sample;

    typedef struct {
        logic               wr_scale;
        logic signed [31:0] scale;
        t_sample            smp;
        logic               typed;
        ert_pkg::t_result   want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic signed [31:0] i_cfg_wdata = '0;
    logic               push = 1'b0;
    logic               full;
    logic               i_operational = 1'b0;
    logic signed [31:0] i_hw_count = '0;
    logic signed [31:0] i_ext_latch = '0;
    logic               i_latch_valid = 1'b0;
    logic               i_set_done = 1'b0;
    logic               i_index_level = 1'b0;
    logic               i_reset_req = 1'b0;
    logic               i_arm_index = 1'b0;
    logic               i_arm_latch_pos = 1'b0;
    logic               i_arm_latch_neg = 1'b0;
    logic               i_request_set = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_hw_count_out;
    logic signed [31:0] o_ext_latch_out;
    logic signed [31:0] o_rel_count;
    logic signed [63:0] o_position;
    logic               o_index_armed_out;
    logic               o_latch_pos_armed_out;
    logic               o_latch_neg_armed_out;
    logic               o_set_pending_out;

    // tracker state as the block should hold it
    logic signed [31:0] trk_scale       = ert_pkg::SCALE_RESET;
    logic signed [31:0] trk_base        = '0;
    logic signed [31:0] trk_rel         = '0;
    logic               trk_prev_z      = 1'b0;
    logic               trk_need_init   = 1'b1;
    logic               trk_link_up     = 1'b0;
    logic               trk_idx_armed   = 1'b0;
    logic               trk_lpos_armed  = 1'b0;
    logic               trk_lneg_armed  = 1'b0;
    logic               trk_preset_pend = 1'b0;
    logic signed [31:0] trk_count_hold  = '0;
    logic signed [31:0] trk_latch_hold  = '0;

    ert_pkg::t_result position_q[$];

    logic signed [31:0] walk_count = '0;
    logic               walk_z     = 1'b0;

    int  errors     = 0;
    int  n_results  = 0;
    int  n_sent     = 0;
    int  n_ignored  = 0;
    int  gap_pct    = 0;
    int  stall_pct  = 0;
    int  stall_left = 0;
    bit  calm       = 1'b0;

    t_dir_row dir_rows [N_DIRECTED];

    encoder_relative_count_tracker_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .push                 (push),
        .full                 (full),
        .i_operational        (i_operational),
        .i_hw_count           (i_hw_count),
        .i_ext_latch          (i_ext_latch),
        .i_latch_valid        (i_latch_valid),
        .i_set_done           (i_set_done),
        .i_index_level        (i_index_level),
        .i_reset_req          (i_reset_req),
        .i_arm_index          (i_arm_index),
        .i_arm_latch_pos      (i_arm_latch_pos),
        .i_arm_latch_neg      (i_arm_latch_neg),
        .i_request_set        (i_request_set),
        .empty                (empty),
        .pop                  (pop),
        .o_hw_count_out       (o_hw_count_out),
        .o_ext_latch_out      (o_ext_latch_out),
        .o_rel_count          (o_rel_count),
        .o_position           (o_position),
        .o_index_armed_out    (o_index_armed_out),
        .o_latch_pos_armed_out(o_latch_pos_armed_out),
        .o_latch_neg_armed_out(o_latch_neg_armed_out),
        .o_set_pending_out    (o_set_pending_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // advance the tracker by one request; returns 1 when the request yields a result
    function automatic bit track_encoder(input t_sample s, output ert_pkg::t_result res);
        logic               z_rise;
        logic signed [63:0] rel_w;
        logic signed [63:0] scale_w;
        res = '0;
        if (!s.operational) begin
            trk_link_up = 1'b0;
            return 1'b0;
        end
        if (!trk_link_up)
            trk_base = s.hw_count;
        if (s.request_set)   trk_preset_pend = 1'b1;
        if (s.arm_index)     trk_idx_armed   = 1'b1;
        if (s.arm_latch_pos) trk_lpos_armed  = 1'b1;
        if (s.arm_latch_neg) trk_lneg_armed  = 1'b1;
        if (s.set_done) begin
            trk_base        = s.hw_count;
            trk_preset_pend = 1'b0;
        end
        if (!trk_preset_pend)
            trk_count_hold = s.hw_count;
        z_rise     = s.index_level && !trk_prev_z;
        trk_prev_z = s.index_level;
        // init or reset request swallows any index edge of the same request
        if (trk_need_init || s.reset_req) begin
            trk_need_init = 1'b0;
            trk_base      = s.hw_count;
            trk_rel       = '0;
            z_rise        = 1'b0;
        end
        if (s.latch_valid) begin
            trk_latch_hold = s.ext_latch;
            trk_base       = s.ext_latch;
            trk_rel        = '0;
            trk_lpos_armed = 1'b0;
            trk_lneg_armed = 1'b0;
        end
        if (z_rise && trk_idx_armed) begin
            trk_base      = s.hw_count;
            trk_rel       = '0;
            trk_idx_armed = 1'b0;
        end
        trk_rel     = trk_rel + (s.hw_count - trk_base);
        trk_base    = s.hw_count;
        trk_link_up = 1'b1;
        rel_w   = trk_rel;
        scale_w = trk_scale;
        res.hw_count  = trk_count_hold;
        res.ext_latch = trk_latch_hold;
        res.rel_count = trk_rel;
        res.position  = rel_w * scale_w;
        res.flags     = {trk_idx_armed, trk_lpos_armed, trk_lneg_armed, trk_preset_pend};
        return 1'b1;
    endfunction

    // mostly a slow encoder walk, with jumps, wraps and sparse events
    function automatic t_sample encoder_sample();
        t_sample s;
        int      mode;
        s = '0;
        s.operational = ($urandom_range(99) < 92);
        mode = $urandom_range(99);
        if (mode < 78)
            walk_count = walk_count + $signed($urandom_range(400)) - 200;
        else if (mode < 88)
            walk_count = $urandom();
        else if (mode < 94)
            walk_count = 32'h7FFF_FFE0 + $urandom_range(63);
        else
            walk_count = walk_count + $signed($urandom());
        s.hw_count  = walk_count;
        s.ext_latch = $urandom_range(1) ? walk_count - $signed($urandom_range(60))
                                        : $signed($urandom());
        if ($urandom_range(99) < 18)
            walk_z = ~walk_z;
        s.index_level   = walk_z;
        s.latch_valid   = ($urandom_range(99) < 6);
        s.set_done      = ($urandom_range(99) < 9);
        s.reset_req     = ($urandom_range(99) < 3);
        s.arm_index     = ($urandom_range(99) < 12);
        s.arm_latch_pos = ($urandom_range(99) < 10);
        s.arm_latch_neg = ($urandom_range(99) < 10);
        s.request_set   = ($urandom_range(99) < 8);
        return s;
    endfunction

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (position_q.size() != 0);
    endtask

    task automatic write_scale(input logic signed [31:0] value);
        drain();
        // non-operational requests give no result and are not queued inside the block
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        trk_scale  = value;
    endtask

    task automatic send_request(input t_sample s, input logic typed,
                                input ert_pkg::t_result want);
        ert_pkg::t_result res;
        if (!calm && $urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_operational   <= s.operational;
        i_hw_count      <= s.hw_count;
        i_ext_latch     <= s.ext_latch;
        i_latch_valid   <= s.latch_valid;
        i_set_done      <= s.set_done;
        i_index_level   <= s.index_level;
        i_reset_req     <= s.reset_req;
        i_arm_index     <= s.arm_index;
        i_arm_latch_pos <= s.arm_latch_pos;
        i_arm_latch_neg <= s.arm_latch_neg;
        i_request_set   <= s.request_set;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
        if (track_encoder(s, res))
            position_q.push_back(typed ? want : res);
        else
            n_ignored++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // result side: check at the edge, then pick pop for the next cycle
    always @(posedge i_clk) begin
        ert_pkg::t_result exp_r;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (position_q.size() == 0) begin
                $error("result with no request waiting: rel_count %0d", o_rel_count);
                errors++;
            end else begin
                exp_r = position_q.pop_front();
                check_field("hw_count_out", exp_r.hw_count, o_hw_count_out);
                check_field("ext_latch_out", exp_r.ext_latch, o_ext_latch_out);
                check_field("rel_count", exp_r.rel_count, o_rel_count);
                check_field("position", exp_r.position, o_position);
                check_field("index_armed_out", exp_r.flags.index_armed, o_index_armed_out);
                check_field("latch_pos_armed_out", exp_r.flags.latch_pos_armed,
                            o_latch_pos_armed_out);
                check_field("latch_neg_armed_out", exp_r.flags.latch_neg_armed,
                            o_latch_neg_armed_out);
                check_field("set_pending_out", exp_r.flags.set_pending, o_set_pending_out);
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end else if (!calm && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(3);
            pop        <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $error("no request moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic signed [31:0] phase_scale [N_PHASES];
        int                 phase_ops;

        //  wr  scale          op  hw_count       ext_latch      lv sd z rst ai ap an rs
        //  typed  expected {hw_count, ext_latch, rel_count, position, flags}
        dir_rows = '{
            // first request after reset zeroes the count
            '{0, 0, '{1, 100, 0, 0,0,0,0,0,0,0,0},            1, '{100, 0, 0, 0, 4'b0000}},
            '{0, 0, '{1, 32'h8000_0000, 0, 0,0,0,0,0,0,0,0},  0, '0},
            '{0, 0, '{1, 32'h7FFF_FFFF, 0, 0,0,0,0,0,0,0,0},  0, '0},
            '{0, 0, '{1, 5, 0, 0,0,0,1,0,0,0,0},              1, '{5, 0, 0, 0, 4'b0000}},
            // link down: arms and requests ignored
            '{0, 0, '{0, 1000, 0, 0,0,0,0,1,1,0,1},           0, '0},
            // link up rebases on the raw count
            '{0, 0, '{1, 2000, 0, 0,0,0,0,0,0,0,0},           1, '{2000, 0, 0, 0, 4'b0000}},
            '{0, 0, '{1, 2010, 0, 0,0,0,0,1,1,1,1},
              1, '{2000, 0, 10, 655360, 4'b1111}},
            // armed index edge zeroes and disarms
            '{0, 0, '{1, 2020, 0, 0,0,1,0,0,0,0,0},           1, '{2000, 0, 0, 0, 4'b0111}},
            '{0, 0, '{1, 2030, 0, 0,0,1,0,0,0,0,0},           0, '0},
            '{0, 0, '{1, 2040, 0, 0,1,0,0,0,0,0,0},           0, '0},
            '{0, 0, '{1, 3000, 2500, 1,0,0,0,0,0,0,0},
              1, '{3000, 2500, 500, 32768000, 4'b0000}},
            // latch without any arm set, extremes of both counts
            '{0, 0, '{1, 32'h7FFF_FFFF, 32'h8000_0000, 1,0,0,0,0,0,0,0},
              1, '{32'h7FFF_FFFF, 32'h8000_0000, -32'sd1, -64'sd65536, 4'b0000}},
            '{0, 0, '{1, 0, 0, 0,0,0,0,0,0,0,0},              0, '0},
            '{0, 0, '{1, 50, 0, 0,0,1,0,1,0,0,0},             0, '0},
            '{0, 0, '{1, 60, 0, 0,0,0,0,1,0,0,0},             0, '0},
            // reset request discards the index edge, arm stays
            '{0, 0, '{1, 70, 0, 0,0,1,1,0,0,0,0},             0, '0},
            '{0, 0, '{1, 80, 0, 0,0,0,0,0,0,0,0},             0, '0},
            '{0, 0, '{1, 90, 75, 1,0,1,0,0,0,0,0},            0, '0},
            // zero scale used as given
            '{1, 0, '{1, 1000, 0, 0,0,0,0,0,0,0,0},           0, '0},
            '{1, 32'h8000_0000, '{1, 32'h8000_0000, 0, 1,0,0,0,0,0,0,0},
              1, '{32'h8000_0000, 0, 32'h8000_0000, 64'h4000_0000_0000_0000, 4'b0000}},
            '{1, 32'h7FFF_FFFF, '{1, 0, 1, 1,0,0,0,0,0,0,0},
              1, '{0, 1, -32'sd1, -64'sd2147483647, 4'b0000}},
            // preset requested and acknowledged at once
            '{1, -32'sd1, '{1, 32'h7FFF_FFFF, 0, 0,1,0,0,0,0,0,1}, 0, '0},
            '{1, ert_pkg::SCALE_RESET, '{1, -32'sd1, 32'h7FFF_FFFF, 1,0,0,0,0,0,1,0}, 0, '0},
            '{0, 0, '{0, -32'sd1, -32'sd1, 1,1,1,1,1,1,1,1},  0, '0},
            '{0, 0, '{1, 12345, 0, 0,0,1,0,0,0,0,0},          0, '0}
        };

        phase_scale = '{ert_pkg::SCALE_RESET, 32'sd0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'sd1, -32'sd1, $urandom(), $urandom_range(32'h3_FFFF)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].wr_scale)
                write_scale(dir_rows[i].scale);
            send_request(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_scale(phase_scale[p]);
            gap_pct   = (p % 3 == 0) ? 0 : 25;
            stall_pct = (p % 2 == 0) ? 30 : 10;
            if (p == N_PHASES - 1)
                calm = 1'b1;
            phase_ops = 0;
            while (phase_ops < PHASE_ITEMS) begin
                // let the result side empty out completely once
                if (p == 1 && phase_ops == PHASE_ITEMS / 2)
                    drain();
                send_request(encoder_sample(), 1'b0, '0);
                phase_ops++;
            end
        end

        drain();
        repeat (TAIL) @(posedge i_clk);
        if (position_q.size() != 0) begin
            $error("%0d results never arrived", position_q.size());
            errors++;
        end

        $display("covered %0d requests (%0d with link down), %0d results checked",
                 n_sent, n_ignored, n_results);
        $display("scale settings: reset value, zero, both extremes, +/-1 lsb and random");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== encoder_relative_count_tracker_top.f =====
src/ert_pkg.sv
src/ert_fifo.sv
src/ert_front.sv
src/ert_back.sv
src/encoder_relative_count_tracker_top.sv
bench/tb_top.sv
